### src/cubemap_texel_direction_assert.svh
// Assertion macros shared by the cubemap texel direction RTL.
`ifndef CUBEMAP_TEXEL_DIRECTION_ASSERT_SVH
`define CUBEMAP_TEXEL_DIRECTION_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define CTD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define CTD_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

### src/ctd_pkg.sv
// Shared constants and types of the cubemap texel direction block.
package ctd_pkg;

   localparam int MAX_FACE_LOG2_DEF = 12;
   localparam int FRAC_BITS_DEF     = 15;

   localparam int FACE_W    = 3;
   localparam int MIP_W     = 4;
   localparam int TEX_W     = 12;
   localparam int FS_W      = 13;
   localparam int ML_W      = 4;
   localparam int DIR_W     = 16;
   localparam int IDX_W     = 27;
   localparam int Q_W       = 16;
   localparam int CSR_IDX_W = 1;
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 80;
   localparam int LEVELS    = 1 << MIP_W;

   localparam logic [FS_W-1:0]  FACE_SIZE_RST  = 13'd256;
   localparam logic [ML_W-1:0]  MIP_LEVELS_RST = 4'd9;
   localparam logic [DIR_W-1:0] DIR_MAX        = 16'h7FFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FACE_SIZE  = 1'b0,
      CSR_MIP_LEVELS = 1'b1
   } csr_index_type;

   typedef enum logic [FACE_W-1:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

endpackage

### src/ctd_norm_step.sv
// One bit of the rounded normalization search for one vector component.
module ctd_norm_step #(
   parameter int NW = 2 * (ctd_pkg::MAX_FACE_LOG2_DEF + 1),
   parameter int RW = NW + 36,
   parameter int K  = 0
) (
   input  logic signed [RW-1:0]          r_i,
   input  logic signed [RW-1:0]          p_i,
   input  logic        [NW-1:0]          n_i,
   input  logic        [ctd_pkg::Q_W-1:0] q_i,
   output logic signed [RW-1:0]          r_o,
   output logic signed [RW-1:0]          p_o,
   output logic        [ctd_pkg::Q_W-1:0] q_o
);
   import ctd_pkg::*;

   logic signed [RW-1:0] ne;
   logic signed [RW-1:0] d;
   logic signed [RW-1:0] rt;
   logic                 ok;

   // r = M - t*t*N, p = t*N with t = 2q-1; trying bit K grows t by 2^(K+1)
   always_comb begin
      ne  = $signed({{(RW-NW){1'b0}}, n_i});
      d   = (p_i <<< (K + 2)) + (ne <<< (2 * K + 2));
      rt  = r_i - d;
      ok  = !rt[RW-1] && ((K == Q_W - 1) || !q_i[Q_W-1]);
      r_o = ok ? rt : r_i;
      p_o = ok ? (p_i + (ne <<< (K + 1))) : p_i;
      q_o = ok ? (q_i | (Q_W'(1) << K)) : q_i;
   end

endmodule

### src/cubemap_texel_direction.sv
// Top level: cubemap texel address to linear index and unit direction.
//
// Usage:
//  - req_ channel carries one texel address per transaction (face, mip,
//    column, row). rsp_ channel returns one transaction per address with the
//    Q1.15 direction, the linear index across the mip chain, and status.
//  - csr_ channel writes face_size (index 0) or mip_levels (index 1); it is
//    always ready. Write only while no transaction is in flight.
//  - Throughput: one transaction per cycle while rsp_tready is high, every
//    stage registered. The depth comes from the normalization search, one
//    result bit per stage over 16 stages with three components side by
//    side, behind six setup stages and ahead of the output register.
//  - Each stage holds valid with its data and loads whenever it is empty or
//    the stage after it moves, so bubbles close up and requests are still
//    taken while a finished response waits on a low rsp_tready. A stall
//    drops and repeats nothing.
//  - Reset (synchronous, active high) empties the pipeline and restores
//    face_size 256 and mip_levels 9.
`include "cubemap_texel_direction_assert.svh"

module cubemap_texel_direction #(
   parameter int MAX_FACE_LOG2 = ctd_pkg::MAX_FACE_LOG2_DEF,
   parameter int FRAC_BITS     = ctd_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // face[2:0], mip[6:3], texel_x[18:7], texel_y[30:19], zero pad
   input  logic [ctd_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // dir_x[15:0], dir_y[31:16], dir_z[47:32], texel_index[74:48], zero pad
   output logic [ctd_pkg::RSP_W-1:0]     rsp_tdata,
   // status[0]
   output logic [0:0]                    rsp_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ctd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ctd_pkg::FS_W-1:0]      csr_data
);
   import ctd_pkg::*;

   localparam int SW  = MAX_FACE_LOG2 + 1;            // side up to 2^MAX_FACE_LOG2
   localparam int CW  = (SW > FS_W) ? SW : FS_W;
   localparam int KW  = (SW > TEX_W) ? SW : TEX_W;
   localparam int AW  = KW + 2;
   localparam int NW  = 2 * SW;                       // squared length
   localparam int SH  = 2 * FRAC_BITS + 2;
   localparam int HR  = (2 * FRAC_BITS + 4 > 36) ? 2 * FRAC_BITS + 4 : 36;
   localparam int RW  = NW + HR;                      // search residue
   localparam int NS  = Q_W;                          // search stages
   localparam int NT  = NS + 7;                       // total stages
   localparam int PAD = RSP_W - 3 * DIR_W - IDX_W;

   // ---------------------------------------------------------------- helpers
   function automatic logic [SW-1:0] clamp_fs(input logic [FS_W-1:0] v);
      logic [CW-1:0] ve;
      logic [CW-1:0] lim;
      ve  = CW'(v);
      lim = CW'(1) << MAX_FACE_LOG2;
      return (ve > lim) ? SW'(lim) : SW'(ve);
   endfunction

   function automatic logic [SW-1:0] mip_side(input logic [SW-1:0] fsc,
                                              input logic [MIP_W-1:0] m);
      logic [SW-1:0] s;
      s = fsc >> m;
      return (s == '0) ? SW'(1) : s;
   endfunction

   function automatic logic [NW-1:0] side_sq(input logic [SW-1:0] s);
      return NW'(s) * NW'(s);
   endfunction

   // ---------------------------------------------------------- config regs
   // sq_ff holds side*side of every mip level, refreshed with face_size
   logic [SW-1:0]   fsc_ff, fsc_in;
   logic [ML_W-1:0] mip_levels_ff;
   logic [NW-1:0]   sq_ff [LEVELS];

   assign csr_ready = 1'b1;
   assign fsc_in    = clamp_fs(csr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         fsc_ff        <= clamp_fs(FACE_SIZE_RST);
         mip_levels_ff <= MIP_LEVELS_RST;
         for (int m = 0; m < LEVELS; m++) begin
            sq_ff[m] <= side_sq(mip_side(clamp_fs(FACE_SIZE_RST), MIP_W'(m)));
         end
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FACE_SIZE: begin
               fsc_ff <= fsc_in;
               for (int m = 0; m < LEVELS; m++) begin
                  sq_ff[m] <= side_sq(mip_side(fsc_in, MIP_W'(m)));
               end
            end
            CSR_MIP_LEVELS: begin
               mip_levels_ff <= csr_data[ML_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------- stage types
   typedef struct packed {
      logic [FACE_W-1:0] face;
      logic [MIP_W-1:0]  mip;
      logic [TEX_W-1:0]  x;
      logic [TEX_W-1:0]  y;
   } st0_type;

   typedef struct packed {
      logic [FACE_W-1:0] face;
      logic [MIP_W-1:0]  mip;
      logic [TEX_W-1:0]  x;
      logic [TEX_W-1:0]  y;
      logic [SW-1:0]     side;
      logic              err;
   } st1_type;

   typedef struct packed {
      logic [FACE_W-1:0] face;
      logic [MIP_W-1:0]  mip;
      logic [TEX_W-1:0]  x;
      logic [TEX_W-1:0]  y;
      logic [SW-1:0]     side;
      logic              err;
      logic [SW-1:0]     a_mag;
      logic              a_neg;
      logic [SW-1:0]     b_mag;
      logic              b_neg;
   } st2_type;

   typedef struct packed {
      logic [FACE_W-1:0] face;
      logic [MIP_W-1:0]  mip;
      logic              err;
      logic [NW-1:0]     s2;
      logic [NW-1:0]     a2;
      logic [NW-1:0]     b2;
      logic              a_neg;
      logic              b_neg;
      logic [IDX_W-1:0]  fs2;
      logic [IDX_W-1:0]  ys;
      logic [TEX_W-1:0]  x;
   } st3_type;

   typedef struct packed {
      logic [MIP_W-1:0]      mip;
      logic                  err;
      logic [NW-1:0]         n;
      logic [2:0][NW-1:0]    m2;
      logic [2:0]            neg;
      logic [IDX_W-1:0]      base;
   } st4_type;

   typedef struct packed {
      logic signed [RW-1:0] r;
      logic signed [RW-1:0] p;
      logic [Q_W-1:0]       q;
   } lane_type;

   typedef struct packed {
      lane_type [2:0]    lane;
      logic [NW-1:0]     n;
      logic [2:0]        neg;
      logic [IDX_W-1:0]  base;
      logic [IDX_W-1:0]  off;
      logic [MIP_W-1:0]  mip;
      logic              err;
   } it_type;

   typedef struct packed {
      logic [DIR_W-1:0] dz;
      logic [DIR_W-1:0] dy;
      logic [DIR_W-1:0] dx;
      logic [IDX_W-1:0] idx;
      logic             status;
   } out_type;

   // ---------------------------------------------------------- flow control
   logic [NT-1:0] v_ff;
   logic [NT:0]   en;

   always_comb begin
      en[NT] = rsp_tready;
      for (int i = NT - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NT; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // ---------------------------------------------------------- stage 0: input
   st0_type s0_ff, s0_in;

   assign s0_in.face = req_tdata[2:0];
   assign s0_in.mip  = req_tdata[6:3];
   assign s0_in.x    = req_tdata[18:7];
   assign s0_in.y    = req_tdata[30:19];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_ff <= s0_in;
      end
   end

   // ---------------------------------------------------------- stage 1: side, range
   st1_type s1_ff, s1_in;

   always_comb begin
      s1_in.face = (s0_ff.face > FACE_NEG_Z) ? FACE_NEG_Z : s0_ff.face;
      s1_in.mip  = s0_ff.mip;
      s1_in.x    = s0_ff.x;
      s1_in.y    = s0_ff.y;
      s1_in.side = mip_side(fsc_ff, s0_ff.mip);
      s1_in.err  = (s0_ff.mip >= mip_levels_ff) ||
                   (KW'(s0_ff.x) >= KW'(s1_in.side)) ||
                   (KW'(s0_ff.y) >= KW'(s1_in.side));
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------------- stage 2: centre offsets
   st2_type s2_ff, s2_in;
   logic signed [AW-1:0] sa, sb;

   always_comb begin
      sa = $signed(AW'({s1_ff.x, 1'b1})) - $signed(AW'(s1_ff.side));
      sb = $signed(AW'({s1_ff.y, 1'b1})) - $signed(AW'(s1_ff.side));
      s2_in.face  = s1_ff.face;
      s2_in.mip   = s1_ff.mip;
      s2_in.x     = s1_ff.x;
      s2_in.y     = s1_ff.y;
      s2_in.side  = s1_ff.side;
      s2_in.err   = s1_ff.err;
      s2_in.a_neg = sa[AW-1];
      s2_in.b_neg = sb[AW-1];
      s2_in.a_mag = SW'(sa[AW-1] ? -sa : sa);
      s2_in.b_mag = SW'(sb[AW-1] ? -sb : sb);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_ff <= s2_in;
      end
   end

   // ---------------------------------------------------------- stage 3: squares, index products
   st3_type s3_ff, s3_in;

   always_comb begin
      s3_in.face  = s2_ff.face;
      s3_in.mip   = s2_ff.mip;
      s3_in.err   = s2_ff.err;
      s3_in.s2    = sq_ff[s2_ff.mip];
      s3_in.a2    = NW'(s2_ff.a_mag) * NW'(s2_ff.a_mag);
      s3_in.b2    = NW'(s2_ff.b_mag) * NW'(s2_ff.b_mag);
      s3_in.a_neg = s2_ff.a_neg;
      s3_in.b_neg = s2_ff.b_neg;
      s3_in.fs2   = IDX_W'(s2_ff.face) * IDX_W'(sq_ff[s2_ff.mip]);
      s3_in.ys    = IDX_W'(s2_ff.y) * IDX_W'(s2_ff.side);
      s3_in.x     = s2_ff.x;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_ff <= s3_in;
      end
   end

   // ---------------------------------------------------------- stage 4: face mapping
   // lane 0 is x, 1 is y, 2 is z; magnitudes travel squared
   st4_type s4_ff, s4_in;
   logic an, bn;

   always_comb begin
      an         = s3_ff.a_neg;
      bn         = s3_ff.b_neg;
      s4_in.mip  = s3_ff.mip;
      s4_in.err  = s3_ff.err;
      s4_in.n    = s3_ff.s2 + s3_ff.a2 + s3_ff.b2;
      s4_in.base = s3_ff.fs2 + s3_ff.ys + IDX_W'(s3_ff.x);
      case (s3_ff.face)
         FACE_POS_X: begin
            s4_in.m2  = {s3_ff.a2, s3_ff.b2, s3_ff.s2};
            s4_in.neg = {~an, ~bn, 1'b0};
         end
         FACE_NEG_X: begin
            s4_in.m2  = {s3_ff.a2, s3_ff.b2, s3_ff.s2};
            s4_in.neg = {an, ~bn, 1'b1};
         end
         FACE_POS_Y: begin
            s4_in.m2  = {s3_ff.b2, s3_ff.s2, s3_ff.a2};
            s4_in.neg = {bn, 1'b0, an};
         end
         FACE_NEG_Y: begin
            s4_in.m2  = {s3_ff.b2, s3_ff.s2, s3_ff.a2};
            s4_in.neg = {~bn, 1'b1, an};
         end
         FACE_POS_Z: begin
            s4_in.m2  = {s3_ff.s2, s3_ff.b2, s3_ff.a2};
            s4_in.neg = {1'b0, ~bn, an};
         end
         default: begin
            s4_in.m2  = {s3_ff.s2, s3_ff.b2, s3_ff.a2};
            s4_in.neg = {1'b1, ~bn, ~an};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_ff <= s4_in;
      end
   end

   // ---------------------------------------------------------- stage 5: search setup
   // start at q = 0, t = -1: r = c^2 * 2^SH - N, p = -N
   it_type it0_in;
   it_type it_ff [NS+1];
   it_type it_in [NS+1];
   logic signed [RW-1:0] ne0;
   logic signed [RW-1:0] me0 [3];

   always_comb begin
      ne0 = $signed(RW'(s4_ff.n));
      for (int c = 0; c < 3; c++) begin
         me0[c]            = $signed(RW'(s4_ff.m2[c]));
         it0_in.lane[c].r  = (me0[c] <<< SH) - ne0;
         it0_in.lane[c].p  = -ne0;
         it0_in.lane[c].q  = '0;
      end
      it0_in.n    = s4_ff.n;
      it0_in.neg  = s4_ff.neg;
      it0_in.base = s4_ff.base;
      it0_in.off  = '0;
      it0_in.mip  = s4_ff.mip;
      it0_in.err  = s4_ff.err;
   end

   assign it_in[0] = it0_in;

   always_ff @(posedge clock) begin
      for (int i = 0; i <= NS; i++) begin
         if (en[5+i]) begin
            it_ff[i] <= it_in[i];
         end
      end
   end

   // ---------------------------------------------------------- search stages
   // stage g fixes result bit Q_W-g and adds the size of mip level g-1
   // to the index offset when that level lies below the requested one
   for (genvar g = 1; g <= NS; g++) begin : g_iter
      logic [IDX_W-1:0] lvl;

      assign lvl = (IDX_W'(sq_ff[g-1]) << 2) + (IDX_W'(sq_ff[g-1]) << 1);

      for (genvar c = 0; c < 3; c++) begin : g_lane
         ctd_norm_step #(
            .NW(NW),
            .RW(RW),
            .K (Q_W - g)
         ) u_step (
            .r_i(it_ff[g-1].lane[c].r),
            .p_i(it_ff[g-1].lane[c].p),
            .n_i(it_ff[g-1].n),
            .q_i(it_ff[g-1].lane[c].q),
            .r_o(it_in[g].lane[c].r),
            .p_o(it_in[g].lane[c].p),
            .q_o(it_in[g].lane[c].q)
         );
      end

      assign it_in[g].n    = it_ff[g-1].n;
      assign it_in[g].neg  = it_ff[g-1].neg;
      assign it_in[g].base = it_ff[g-1].base;
      assign it_in[g].mip  = it_ff[g-1].mip;
      assign it_in[g].err  = it_ff[g-1].err;
      assign it_in[g].off  = (MIP_W'(g - 1) < it_ff[g-1].mip) ?
                             (it_ff[g-1].off + lvl) : it_ff[g-1].off;
   end

   // ---------------------------------------------------------- output stage
   // sign, saturate a unit component, zero everything on a range error
   out_type out_ff, out_in;
   logic [DIR_W-1:0] dir [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (it_ff[NS].err) begin
            dir[c] = '0;
         end else if (it_ff[NS].neg[c]) begin
            dir[c] = DIR_W'(-it_ff[NS].lane[c].q);
         end else if (it_ff[NS].lane[c].q[Q_W-1]) begin
            dir[c] = DIR_MAX;
         end else begin
            dir[c] = DIR_W'(it_ff[NS].lane[c].q);
         end
      end
      out_in.dx     = dir[0];
      out_in.dy     = dir[1];
      out_in.dz     = dir[2];
      out_in.idx    = it_ff[NS].err ? '0 : (it_ff[NS].off + it_ff[NS].base);
      out_in.status = it_ff[NS].err;
   end

   always_ff @(posedge clock) begin
      if (en[NT-1]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = v_ff[NT-1];
   assign rsp_tdata  = {{PAD{1'b0}}, out_ff.idx, out_ff.dz, out_ff.dy, out_ff.dx};
   assign rsp_tuser  = out_ff.status;

   // ---------------------------------------------------------- assertions
   `CTD_ASSERT(a_err_zero, (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0), "error data")
   `CTD_ASSERT(a_drain_ready, (!rsp_tvalid) |-> req_tready, "request blocked, output empty")
   `CTD_ASSERT_NEXT(a_take, req_tvalid && req_tready, v_ff[0], "request not captured")

endmodule
